>>> rtl/core/canonical_combining_reorder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the canonical combining reorder block
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_COMBINING_REORDER_ASSERT_SVH
`define CANONICAL_COMBINING_REORDER_ASSERT_SVH

// same-cycle implication
`define CCR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccr assertion failed");

// next-cycle implication
`define CCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccr assertion failed");

`endif

>>> rtl/core/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Types and constants shared by the combining reorder cell chain.
// ----------------------------------------------------------------------------
package ccr_pkg;

	localparam int RUN_DEPTH = 32;
	localparam int CP_W      = 21;
	localparam int CLASS_W   = 8;
	localparam int DATA_W    = 32;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [CP_W-1:0]    cp;
	} entry_t;

	// chain command: parallel insert or drain shift toward the head
	typedef struct packed {
		logic ins;
		logic shift;
	} chain_cmd_t;

	typedef struct packed {
		entry_t head;
		logic   empty;
		logic   full;
		logic   head_last;
	} chain_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

>>> rtl/core/ccr_cell.sv
// ----------------------------------------------------------------------------
// ccr_cell
// One slot of the sorted run: holds an entry and its valid bit.
// ----------------------------------------------------------------------------
module ccr_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ccr_pkg::chain_cmd_t cmd,
	input  ccr_pkg::entry_t     new_ent,
	input  ccr_pkg::entry_t     prev_ent,
	input  logic                prev_vld,
	input  logic                prev_aft,
	input  ccr_pkg::entry_t     next_ent,
	input  logic                next_vld,
	output ccr_pkg::entry_t     ent,
	output logic                vld,
	output logic                aft
);

	ccr_pkg::entry_t ent_q;
	logic            vld_q;

	// at or past the insertion point: empty, or strictly greater class
	assign aft = !vld_q || (ent_q.cls > new_ent.cls);
	assign ent = ent_q;
	assign vld = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.shift) begin
			vld_q <= next_vld;
		end else if (cmd.ins) begin
			vld_q <= vld_q | prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			ent_q <= next_ent;
		end else if (cmd.ins && aft) begin
			ent_q <= prev_aft ? prev_ent : new_ent;
		end
	end

endmodule

>>> rtl/core/ccr_chain.sv
// ----------------------------------------------------------------------------
// ccr_chain
// Row of cells kept sorted by class; inserts in parallel, drains from cell 0.
// ----------------------------------------------------------------------------
module ccr_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccr_pkg::chain_cmd_t  cmd,
	input  ccr_pkg::entry_t      new_ent,
	output ccr_pkg::chain_stat_t stat
);

	`include "canonical_combining_reorder_assert.svh"

	localparam logic [ccr_pkg::RUN_DEPTH-1:0] ONE = {{(ccr_pkg::RUN_DEPTH-1){1'b0}}, 1'b1};

	ccr_pkg::entry_t                 ent [ccr_pkg::RUN_DEPTH];
	logic [ccr_pkg::RUN_DEPTH-1:0]   vld;
	logic [ccr_pkg::RUN_DEPTH-1:0]   aft;

	for (genvar i = 0; i < ccr_pkg::RUN_DEPTH; i++) begin : g_cell
		ccr_pkg::entry_t p_ent, n_ent;
		logic            p_vld, p_aft, n_vld;

		if (i == 0) begin : g_first
			assign p_ent = new_ent;
			assign p_vld = 1'b1;
			assign p_aft = 1'b0;
		end else begin : g_mid
			assign p_ent = ent[i-1];
			assign p_vld = vld[i-1];
			assign p_aft = aft[i-1];
		end

		if (i == ccr_pkg::RUN_DEPTH - 1) begin : g_last
			assign n_ent = ent[i];
			assign n_vld = 1'b0;
		end else begin : g_inner
			assign n_ent = ent[i+1];
			assign n_vld = vld[i+1];
		end

		ccr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.new_ent  (new_ent),
			.prev_ent (p_ent),
			.prev_vld (p_vld),
			.prev_aft (p_aft),
			.next_ent (n_ent),
			.next_vld (n_vld),
			.ent      (ent[i]),
			.vld      (vld[i]),
			.aft      (aft[i])
		);
	end

	assign stat.head      = ent[0];
	assign stat.empty     = !vld[0];
	assign stat.full      = vld[ccr_pkg::RUN_DEPTH-1];
	assign stat.head_last = !vld[1];

	// occupied cells always form a prefix of the row
	`CCR_ASSERT_NOW(a_prefix, 1'b1, ((vld + ONE) & vld) == '0)
	`CCR_ASSERT_NOW(a_no_ins_full, cmd.ins, !stat.full)
	`CCR_ASSERT_NOW(a_one_cmd, 1'b1, !(cmd.ins && cmd.shift))

endmodule

>>> rtl/core/canonical_combining_reorder.sv
// ----------------------------------------------------------------------------
// canonical_combining_reorder
// Canonical ordering of combining marks over a code point stream.
//
//  channel  dir  tdata (low bit up)              tlast         tuser
//  s_axis   in   code_point, combining_class     end_marker    -
//  m_axis   out  out_code_point, out_class      run_last      forced_flush
//
//  A mark with a free cell is inserted in the cycle it is accepted, so a run
//  of marks streams in at one transaction per cycle outside a drain.
//  A flush (starter or end marker on a held run, or a mark on a full row)
//  drains the row one item per cycle at cell 0 while the output is free,
//  then stores the pending item, if the flush was not an end marker.
//  s_axis_tready is low for the whole drain.
//  arst_n clears the valid bits of all cells, the state and the output valid.
// ----------------------------------------------------------------------------
module canonical_combining_reorder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [ccr_pkg::DATA_W-1:0]  s_axis_tdata,  // code_point[20:0], combining_class[28:21]
	input  logic                        s_axis_tlast,  // end_marker
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [ccr_pkg::DATA_W-1:0]  m_axis_tdata,  // out_code_point[20:0], out_class[28:21]
	output logic                        m_axis_tlast,  // run_last
	output logic                        m_axis_tuser   // forced_flush
);

	`include "canonical_combining_reorder_assert.svh"

	localparam int ENT_W = ccr_pkg::CP_W + ccr_pkg::CLASS_W;

	ccr_pkg::state_t      state_q, state_nxt;
	ccr_pkg::chain_cmd_t  cmd;
	ccr_pkg::chain_stat_t stat;
	ccr_pkg::entry_t      in_ent, pend_ent_q, new_ent;
	logic                 pend_q, forced_q;
	logic                 acc, is_start, flush_req, out_free;

	logic                 m_vld_q, m_last_q, m_user_q;
	ccr_pkg::entry_t      m_ent_q;

	// input unpack: code point in the low bits, class above it
	assign in_ent.cp  = s_axis_tdata[ccr_pkg::CP_W-1:0];
	assign in_ent.cls = s_axis_tdata[ENT_W-1:ccr_pkg::CP_W];

	assign acc      = s_axis_tvalid && s_axis_tready;
	assign is_start = (in_ent.cls == '0);
	// held run must leave before this transaction can be stored
	assign flush_req = acc && !stat.empty && (s_axis_tlast || is_start || stat.full);
	assign out_free  = !m_vld_q || m_axis_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ccr_pkg::ST_IDLE: begin
				if (flush_req) state_nxt = ccr_pkg::ST_DRAIN;
			end
			ccr_pkg::ST_DRAIN: begin
				if (stat.empty) state_nxt = ccr_pkg::ST_IDLE;
			end
			default: state_nxt = ccr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		new_ent       = in_ent;
		unique case (state_q)
			ccr_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.ins       = acc && !flush_req && !s_axis_tlast;
			end
			ccr_pkg::ST_DRAIN: begin
				new_ent   = pend_ent_q;
				cmd.shift = !stat.empty && out_free;
				cmd.ins   = stat.empty && pend_q;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ccr_pkg::ST_IDLE;
			pend_q   <= 1'b0;
			forced_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (flush_req) begin
				pend_q   <= !s_axis_tlast;
				// only a mark meeting a full row forces the flush
				forced_q <= !s_axis_tlast && !is_start;
			end else if (state_q == ccr_pkg::ST_DRAIN && stat.empty) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flush_req) pend_ent_q <= in_ent;
	end

	ccr_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.new_ent (new_ent),
		.stat    (stat)
	);

	// output register: cell 0 moves here on every drain shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (cmd.shift) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			m_ent_q  <= stat.head;
			m_last_q <= stat.head_last;
			m_user_q <= forced_q;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {{(ccr_pkg::DATA_W-ENT_W){1'b0}}, m_ent_q.cls, m_ent_q.cp};
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

	`CCR_ASSERT_NEXT(a_flush_drains, flush_req, state_q == ccr_pkg::ST_DRAIN)
	`CCR_ASSERT_NOW(a_pend_in_drain, pend_q, state_q == ccr_pkg::ST_DRAIN)
	`CCR_ASSERT_NEXT(a_last_empties, cmd.shift && stat.head_last, stat.empty)

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: canonical_combining_reorder testbench
// Streams code points with combining classes into the block, keeps its own
// copy of the held run to work out each emitted item, and checks every output
// transaction field by field. Both sides idle at random; the output side is
// also held off for a long stretch so the row fills and the input stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam int RUN_DEPTH   = ccr_pkg::RUN_DEPTH;
	localparam int CP_W        = ccr_pkg::CP_W;
	localparam int CLASS_W     = ccr_pkg::CLASS_W;
	localparam int DATA_W      = ccr_pkg::DATA_W;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PAD_W       = DATA_W - CP_W - CLASS_W;

	// one emitted item as the block should present it
	typedef struct {
		logic [CP_W-1:0]    cp;
		logic [CLASS_W-1:0] cls;
		logic               last;
		logic               forced;
	} emit_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic              s_axis_tlast  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic              m_axis_tuser;

	// held run as the block should see it, and the items owed downstream
	ccr_pkg::entry_t held_run [RUN_DEPTH];
	int              held_n = 0;
	emit_t           canon_q [$];

	int   mismatches  = 0;
	int   idle_cycles = 0;
	logic calm        = 1'b0; // no idling on either side while set
	int   hold_req    = 0;    // bumped to ask the output side for a long hold
	int   hold_seen   = 0;
	int   hold_left   = 0;
	int   rx_wait     = 0;

	canonical_combining_reorder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Ordering predictor
	// ------------------------------------------------------------------------

	// hand the whole held run downstream in stored order
	task automatic flush_run(input logic forced);
		emit_t e;
		for (int i = 0; i < held_n; i++) begin
			e.cp     = held_run[i].cp;
			e.cls    = held_run[i].cls;
			e.last   = (i == held_n - 1);
			e.forced = forced;
			canon_q.push_back(e);
		end
		held_n = 0;
	endtask

	task automatic canon_reorder(input ccr_pkg::entry_t ent, input logic end_mark);
		int pos;
		if (end_mark) begin
			flush_run(1'b0);
		end else if (ent.cls == '0) begin
			// starter closes the held run, even when the row is full
			flush_run(1'b0);
			held_run[0] = ent;
			held_n      = 1;
		end else begin
			if (held_n >= RUN_DEPTH)
				flush_run(1'b1);
			// stable insert: goes behind every item of lower or equal class
			pos = held_n;
			while (pos > 0 && held_run[pos-1].cls > ent.cls) begin
				held_run[pos] = held_run[pos-1];
				pos--;
			end
			held_run[pos] = ent;
			held_n++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_emit(input logic [DATA_W-1:0] data, input logic last,
	                          input logic forced);
		emit_t want;
		if (canon_q.size() == 0) begin
			report_mismatch($sformatf("item with nothing owed: tdata=%h", data));
		end else begin
			want = canon_q.pop_front();
			if (data[CP_W-1:0] !== want.cp)
				report_mismatch($sformatf("code point %h, want %h",
				                          data[CP_W-1:0], want.cp));
			if (data[CP_W +: CLASS_W] !== want.cls)
				report_mismatch($sformatf("class %0d, want %0d (cp %h)",
				                          data[CP_W +: CLASS_W], want.cls, want.cp));
			if (data[DATA_W-1 -: PAD_W] !== '0)
				report_mismatch($sformatf("tdata pad bits %b", data[DATA_W-1 -: PAD_W]));
			if (last !== want.last)
				report_mismatch($sformatf("run_last %b, want %b (cp %h)",
				                          last, want.last, want.cp));
			if (forced !== want.forced)
				report_mismatch($sformatf("forced_flush %b, want %b (cp %h)",
				                          forced, want.forced, want.cp));
		end
	endtask

	// output side: checks each transaction, then draws its stall for the next
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_emit(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			rx_wait = calm ? 0 : $urandom_range(0, 3);
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog: too long without a transaction on either side ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic logic [CP_W-1:0] rand_cp();
		return CP_W'($urandom_range(0, (1 << CP_W) - 1));
	endfunction

	// mostly the common above/below classes, so equal classes meet often
	function automatic logic [CLASS_W-1:0] rand_mark_class();
		case ($urandom_range(0, 3))
			0:       return 8'd230;
			1:       return 8'd220;
			2:       return CLASS_W'($urandom_range(200, 240));
			default: return CLASS_W'($urandom_range(1, 255));
		endcase
	endfunction

	// one input transaction; returns at the edge where it is accepted
	task automatic send_item(input logic [CP_W-1:0] cp, input logic [CLASS_W-1:0] cls,
	                         input logic end_mark);
		int              gap;
		ccr_pkg::entry_t ent;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ent.cp  = cp;
		ent.cls = cls;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{PAD_W{1'b0}}, cls, cp};
		s_axis_tlast  <= end_mark;
		do @(posedge clk); while (!s_axis_tready);
		canon_reorder(ent, end_mark);
	endtask

	// sender goes quiet until everything owed has come out
	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		while (canon_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_special_cases();
		// end of text with nothing held: no output, code point ignored
		send_item(21'h000041, 8'd0, 1'b1);
		// marks ahead of any starter form a run of their own
		send_item(21'h000301, 8'd230, 1'b0);
		send_item(21'h000316, 8'd220, 1'b0);
		send_item(21'h000302, 8'd230, 1'b0); // equal class keeps arrival order
		send_item(21'h1FFFFF, 8'd255, 1'b0); // beyond 10FFFF, top class
		send_item(21'h00D800, 8'd1, 1'b0);   // surrogates pass through
		send_item(21'h00D801, 8'd1, 1'b0);
		send_item(21'h1FFFFF, 8'hFF, 1'b1);  // end marker flushes, fields ignored
		// starter with nothing held only stores
		send_item(21'h000000, 8'd0, 1'b0);
		send_item(21'h000327, 8'd202, 1'b0);
		send_item(21'h000345, 8'd240, 1'b0);
		send_item(21'h000323, 8'd220, 1'b0);
		send_item(21'h000300, 8'd230, 1'b0);
		send_item(21'h10FFFF, 8'd0, 1'b0);   // starter closes the run
		send_item(21'h110000, 8'd0, 1'b0);   // back to back: one-item run
		send_item(21'h0AAAAA, 8'h80, 1'b0);
		send_item(21'h155555, 8'h7F, 1'b0);
		send_item(21'h000000, 8'd0, 1'b1);
		send_item(21'h000000, 8'd0, 1'b1);   // nothing held again
		pause_until_drained();
	endtask

	task automatic test_full_row();
		calm <= 1'b1;
		// starter plus marks fill every cell; one more mark forces an early flush
		send_item(rand_cp(), 8'd0, 1'b0);
		for (int i = 1; i < RUN_DEPTH; i++)
			send_item(rand_cp(), rand_mark_class(), 1'b0);
		send_item(rand_cp(), rand_mark_class(), 1'b0);
		// mark-only run fills the row, then a starter flushes it normally
		for (int i = 1; i < RUN_DEPTH; i++)
			send_item(rand_cp(), rand_mark_class(), 1'b0);
		send_item(rand_cp(), 8'd0, 1'b0);
		// full row closed by the end marker
		for (int i = 1; i < RUN_DEPTH; i++)
			send_item(rand_cp(), rand_mark_class(), 1'b0);
		send_item(rand_cp(), rand_mark_class(), 1'b1);
		pause_until_drained();
	endtask

	task automatic test_output_stall();
		calm <= 1'b0;
		// output held off while the row fills and a forced flush backs up
		hold_req <= hold_req + 1;
		send_item(rand_cp(), 8'd0, 1'b0);
		for (int i = 0; i < RUN_DEPTH + 8; i++)
			send_item(rand_cp(), rand_mark_class(), 1'b0);
		send_item(rand_cp(), 8'd0, 1'b1);
		pause_until_drained();
	endtask

	task automatic test_random_runs(input int n_items);
		int sent;
		int n_marks;
		int kind;
		sent = 0;
		while (sent < n_items) begin
			calm <= ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				// well-formed: starter and its marks
				send_item(rand_cp(), 8'd0, 1'b0);
				sent++;
				n_marks = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
				                                        : $urandom_range(0, 5);
				for (int i = 0; i < n_marks; i++)
					send_item(rand_cp(), rand_mark_class(), 1'b0);
				sent += n_marks;
			end else if (kind < 16) begin
				send_item(rand_cp(), CLASS_W'($urandom_range(0, 255)), 1'b1);
				sent++;
			end else if (kind < 18) begin
				// stray marks after a flush, before any starter
				send_item(rand_cp(), 8'd0, 1'b1);
				n_marks = $urandom_range(1, 4);
				for (int i = 0; i < n_marks; i++)
					send_item(rand_cp(), rand_mark_class(), 1'b0);
				sent += n_marks + 1;
			end else begin
				// noise: any field values at all
				send_item(rand_cp(), CLASS_W'($urandom_range(0, 255)),
				          1'($urandom_range(0, 1)));
				sent++;
			end
		end
		send_item(rand_cp(), CLASS_W'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_full_row();
		test_output_stall();
		test_random_runs(150);
		pause_until_drained();
		// let any stray transaction show up before the verdict
		repeat (RUN_DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> canonical_combining_reorder.f
+incdir+rtl/core
rtl/core/ccr_pkg.sv
rtl/core/ccr_cell.sv
rtl/core/ccr_chain.sv
rtl/core/canonical_combining_reorder.sv
dv/tb.sv
